FILE: rtl/sci_pkg.sv
// Shared types, codes and constants for the shelf carousel indexer.
package sci_pkg;

   // Number of shelves on the carousel.
   localparam int unsigned SHELVES = 8;

   // Field widths.
   localparam int unsigned REQ_TYPE_W = 2;
   localparam int unsigned SHELF_W    = 4;
   localparam int unsigned TICKS_W    = 16;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = TICKS_W;
   localparam int unsigned DIFF_W     = SHELF_W + 2;
   localparam int unsigned LUT_DEPTH  = 2 ** (DIFF_W - 1);

   // Reset values.
   localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = TICKS_W'(500);
   localparam logic [SHELF_W-1:0] HOME_POS_RESET = SHELF_W'(2);
   localparam logic [SHELF_W-1:0] POSITION_RESET = SHELF_W'(10);
   localparam logic [TICKS_W-1:0] TICKS_MAX      = '1;

   // Request codes.
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_TICK = 2'd0,
      REQ_GO   = 2'd1,
      REQ_HOME = 2'd2,
      REQ_NONE = 2'd3
   } req_code_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_POS = 1'b1;

   // Carousel control modes.
   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_MOVING = 3'b010,
      MODE_HOMING = 3'b100
   } mode_type;

   typedef logic [SHELF_W-1:0] spacing_lut_type [LUT_DEPTH];

   // Remainder of a non-negative distance by the shelf count, built at elaboration.
   function automatic spacing_lut_type build_spacing_lut();
      spacing_lut_type lut;
      for (int i = 0; i < LUT_DEPTH; i++) begin
         lut[i] = SHELF_W'(i % SHELVES);
      end
      return lut;
   endfunction

   localparam spacing_lut_type SPACING_LUT = build_spacing_lut();

endpackage

FILE: rtl/sci_req_if.sv
// Request channel interface of the shelf carousel indexer.
interface sci_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [3:0] target_shelf;
   logic       shelf_sensor;
   logic       home_sensor;

   modport source (output valid, req_type, target_shelf, shelf_sensor, home_sensor,
                   input ready);
   modport sink (input valid, req_type, target_shelf, shelf_sensor, home_sensor,
                 output ready);
endinterface

FILE: rtl/sci_rsp_if.sv
// Result channel interface of the shelf carousel indexer.
interface sci_rsp_if;
   logic       valid;
   logic       ready;
   logic       motor_run;
   logic       busy_res;
   logic       done_res;
   logic [3:0] position;
   logic [3:0] shelves_passed;
   logic       rejected;

   modport source (output valid, motor_run, busy_res, done_res, position, shelves_passed,
                   rejected, input ready);
   modport sink (input valid, motor_run, busy_res, done_res, position, shelves_passed,
                 rejected, output ready);
endinterface

FILE: rtl/shelf_carousel_indexer.sv
// A request is registered in the input register on acceptance, and its result is registered
// in the result register when the input stage moves on.
// Throughput: one request per cycle; while a result waits downstream the input register
// takes one more request and then the input stalls until the result is taken.
// Reset: synchronous, active high; mode idle, position 10, counters cleared,
// debounce lockout 500 ticks and home position 2.
module shelf_carousel_indexer (
   input  logic                         clock,
   input  logic                         reset,
   sci_req_if.sink                      req_chan,
   sci_rsp_if.source                    rsp_chan,
   input  logic                         csr_write,
   input  logic [sci_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sci_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sci_pkg::*;

   // Configuration registers.
   logic [TICKS_W-1:0] debounce_ff;
   logic [SHELF_W-1:0] home_pos_ff;

   // Input register.
   logic                  stage_valid_ff;
   logic [REQ_TYPE_W-1:0] stage_req_ff;
   logic [SHELF_W-1:0]    stage_target_ff;
   logic                  stage_shelf_ff;
   logic                  stage_home_ff;

   // Carousel state.
   mode_type           mode_ff, mode_in;
   logic [SHELF_W-1:0] position_ff, position_in;
   logic [SHELF_W-1:0] goal_ff, goal_in;
   logic [SHELF_W-1:0] passed_ff, passed_in;
   logic               level_ff, level_in;
   logic [TICKS_W-1:0] elapsed_ff, elapsed_in;
   logic [SHELF_W-1:0] target_ff, target_in;

   // Result register.
   logic               rsp_valid_ff;
   logic               rsp_busy_ff;
   logic               rsp_done_ff;
   logic [SHELF_W-1:0] rsp_position_ff;
   logic [SHELF_W-1:0] rsp_passed_ff;
   logic               rsp_rejected_ff;

   logic               advance;
   logic               done_in;
   logic               rejected_in;
   logic               busy_now;
   logic [DIFF_W-1:0]  diff;
   logic [SHELF_W-1:0] spacing;
   logic [TICKS_W-1:0] elapsed_inc;
   logic               change_ok;
   logic [SHELF_W-1:0] passed_inc;

   // Handshake: the input stage moves on when the result register is free or draining.
   assign advance        = stage_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         home_pos_ff <= HOME_POS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_wdata;
            CSR_HOME_POS: home_pos_ff <= csr_wdata[SHELF_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         stage_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         stage_req_ff    <= req_chan.req_type;
         stage_target_ff <= req_chan.target_shelf;
         stage_shelf_ff  <= req_chan.shelf_sensor;
         stage_home_ff   <= req_chan.home_sensor;
      end
   end

   // Shelf spacing: target minus position plus the shelf count; negative means none.
   assign diff    = DIFF_W'(stage_target_ff) + DIFF_W'(SHELVES) - DIFF_W'(position_ff);
   assign spacing = SPACING_LUT[diff[DIFF_W-2:0]];

   // Debounced shelf counting.
   assign elapsed_inc = (elapsed_ff == TICKS_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign change_ok   = (stage_shelf_ff != level_ff) && (elapsed_inc > debounce_ff);
   assign passed_inc  = passed_ff + 1'b1;
   assign busy_now    = (mode_ff == MODE_MOVING) || (mode_ff == MODE_HOMING);

   // Next state for the request in the input register.
   always_comb begin
      mode_in     = mode_ff;
      position_in = position_ff;
      goal_in     = goal_ff;
      passed_in   = passed_ff;
      level_in    = level_ff;
      elapsed_in  = elapsed_ff;
      target_in   = target_ff;
      done_in     = 1'b0;
      rejected_in = 1'b0;
      case (stage_req_ff) inside
         REQ_GO, REQ_HOME: begin
            if (busy_now) begin
               rejected_in = 1'b1;
            end else if (stage_req_ff == REQ_HOME) begin
               mode_in   = MODE_HOMING;
               passed_in = '0;
            end else if (stage_target_ff != '0) begin
               passed_in  = '0;
               level_in   = 1'b0;
               elapsed_in = '0;
               if (!diff[DIFF_W-1] && (spacing != '0)) begin
                  goal_in   = spacing;
                  target_in = stage_target_ff;
                  mode_in   = MODE_MOVING;
               end else begin
                  position_in = stage_target_ff;
                  done_in     = 1'b1;
               end
            end
         end
         REQ_TICK: begin
            if (mode_ff == MODE_MOVING) begin
               elapsed_in = elapsed_inc;
               if (change_ok) begin
                  level_in   = stage_shelf_ff;
                  elapsed_in = '0;
                  if (!stage_shelf_ff) begin
                     passed_in = passed_inc;
                  end
               end
               if (passed_in >= goal_ff) begin
                  position_in = target_ff;
                  mode_in     = MODE_IDLE;
                  done_in     = 1'b1;
               end
            end else if (mode_ff == MODE_HOMING) begin
               if (!stage_home_ff) begin
                  position_in = home_pos_ff;
                  mode_in     = MODE_IDLE;
                  done_in     = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // State update.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         position_ff <= POSITION_RESET;
         goal_ff     <= '0;
         passed_ff   <= '0;
         level_ff    <= 1'b0;
         elapsed_ff  <= '0;
         target_ff   <= '0;
      end else if (advance) begin
         mode_ff     <= mode_in;
         position_ff <= position_in;
         goal_ff     <= goal_in;
         passed_ff   <= passed_in;
         level_ff    <= level_in;
         elapsed_ff  <= elapsed_in;
         target_ff   <= target_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_busy_ff     <= (mode_in == MODE_MOVING) || (mode_in == MODE_HOMING);
         rsp_done_ff     <= done_in;
         rsp_position_ff <= position_in;
         rsp_passed_ff   <= passed_in;
         rsp_rejected_ff <= rejected_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.motor_run      = rsp_busy_ff;
   assign rsp_chan.busy_res       = rsp_busy_ff;
   assign rsp_chan.done_res       = rsp_done_ff;
   assign rsp_chan.position       = rsp_position_ff;
   assign rsp_chan.shelves_passed = rsp_passed_ff;
   assign rsp_chan.rejected       = rsp_rejected_ff;

   // A completed move or homing leaves the carousel idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> !rsp_busy_ff)
      else $error("done result reports busy");

   // A rejected command only happens while busy and leaves the block busy.
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rejected_ff |-> rsp_busy_ff && !rsp_done_ff)
      else $error("rejected result while not busy");

   // A move always has a nonzero spacing goal.
   a_goal_nonzero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_MOVING |-> goal_ff != '0)
      else $error("moving with zero spacing goal");

   // State only changes when a request passes through the input stage.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(mode_ff) && $stable(position_ff) && $stable(passed_ff))
      else $error("state changed without a request");

endmodule

FILE: dv/tb_shelf_carousel_indexer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the shelf carousel indexer: directed table, then random traffic.
module tb_shelf_carousel_indexer;
   import sci_pkg::*;

   localparam int SHELF_COUNT = int'(SHELVES);
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PRINT_LIMIT = 100;
   localparam int DIRECTED_COUNT = 19;
   localparam int LONG_LOCKOUT_TICKS = 60;

   // Carousel modes as the predictor tracks them.
   typedef enum logic [1:0] {
      CAR_IDLE,
      CAR_MOVING,
      CAR_HOMING
   } carousel_mode_type;

   typedef struct packed {
      logic       motor_run;
      logic       busy_res;
      logic       done_res;
      logic [3:0] position;
      logic [3:0] shelves_passed;
      logic       rejected;
   } carousel_status_type;

   typedef struct packed {
      req_code_type        rt;
      logic [3:0]          tgt;
      logic                shelf;
      logic                home;
      logic                pinned;
      carousel_status_type want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sci_req_if req_if ();
   sci_rsp_if rsp_if ();

   shelf_carousel_indexer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state and its copy of the registers.
   carousel_mode_type car_mode = CAR_IDLE;
   logic [3:0]        shelf_pos = 4'd10;
   logic [3:0]        spacing_goal = 4'd0;
   logic [3:0]        shelves_counted = 4'd0;
   logic              sensor_level = 1'b0;
   logic [15:0]       lockout_ticks = 16'd0;
   logic [3:0]        move_target = 4'd0;
   logic [15:0]       cfg_debounce = 16'd500;
   logic [3:0]        cfg_home_pos = 4'd2;

   carousel_status_type expected_status_q [$];
   int                  mismatch_count = 0;
   int                  result_count = 0;
   int                  requests_sent = 0;
   int                  cycle_count = 0;
   bit                  idling_on = 1'b1;

   // Directed stimulus; rows with pinned set carry a hand-written expected status.
   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      // Idle after reset: ticks, the unused code and a zero target leave everything alone.
      '{REQ_TICK, 4'd0,  1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd10, 4'd0, 1'b0}},
      '{REQ_TICK, 4'd15, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd10, 4'd0, 1'b0}},
      '{REQ_NONE, 4'd15, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd10, 4'd0, 1'b0}},
      '{REQ_GO,   4'd0,  1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 4'd10, 4'd0, 1'b0}},
      // Zero spacing, then negative spacing: both complete at once.
      '{REQ_GO,   4'd10, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 4'd10, 4'd0, 1'b0}},
      '{REQ_GO,   4'd1,  1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 4'd1,  4'd0, 1'b0}},
      // Homing ignores the sensors on its own request; commands meanwhile are rejected.
      '{REQ_HOME, 4'd0,  1'b0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 4'd1,  4'd0, 1'b0}},
      '{REQ_GO,   4'd3,  1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 4'd1,  4'd0, 1'b1}},
      '{REQ_GO,   4'd0,  1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 4'd1,  4'd0, 1'b1}},
      '{REQ_HOME, 4'd15, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 4'd1,  4'd0, 1'b1}},
      '{REQ_NONE, 4'd0,  1'b0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 4'd1,  4'd0, 1'b0}},
      '{REQ_TICK, 4'd0,  1'b0, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 4'd1,  4'd0, 1'b0}},
      '{REQ_TICK, 4'd0,  1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 4'd2,  4'd0, 1'b0}},
      // A real move under the reset lockout: sensor changes come far too early.
      '{REQ_GO,   4'd15, 1'b0, 1'b0, 1'b0, '0},
      '{REQ_TICK, 4'd0,  1'b1, 1'b1, 1'b0, '0},
      '{REQ_TICK, 4'd0,  1'b0, 1'b0, 1'b0, '0},
      '{REQ_HOME, 4'd0,  1'b0, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 4'd2,  4'd0, 1'b1}},
      '{REQ_NONE, 4'd15, 1'b1, 1'b1, 1'b0, '0},
      '{REQ_TICK, 4'd0,  1'b1, 1'b0, 1'b0, '0}
   };

   // Clock and run limit.
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Advance the predicted carousel by one accepted request and return its status.
   function automatic carousel_status_type predict_carousel(req_code_type rt,
                                                            logic [3:0] tgt,
                                                            logic shelf, logic home);
      carousel_status_type st;
      logic                done_now;
      logic                rej_now;
      int                  spacing;
      done_now = 1'b0;
      rej_now = 1'b0;
      case (rt)
         REQ_GO, REQ_HOME: begin
            if (car_mode != CAR_IDLE) begin
               rej_now = 1'b1;
            end else if (rt == REQ_HOME) begin
               car_mode = CAR_HOMING;
               shelves_counted = 4'd0;
            end else if (tgt != 4'd0) begin
               spacing = (int'(tgt) - int'(shelf_pos) + SHELF_COUNT) % SHELF_COUNT;
               shelves_counted = 4'd0;
               sensor_level = 1'b0;
               lockout_ticks = 16'd0;
               if (spacing > 0) begin
                  spacing_goal = 4'(spacing);
                  move_target = tgt;
                  car_mode = CAR_MOVING;
               end else begin
                  shelf_pos = tgt;
                  done_now = 1'b1;
               end
            end
         end
         REQ_TICK: begin
            if (car_mode == CAR_MOVING) begin
               if (lockout_ticks != 16'hFFFF) lockout_ticks = lockout_ticks + 16'd1;
               // A level change counts only once the lockout has run out.
               if (shelf != sensor_level && lockout_ticks > cfg_debounce) begin
                  sensor_level = shelf;
                  lockout_ticks = 16'd0;
                  if (!shelf) shelves_counted = shelves_counted + 4'd1;
               end
               if (shelves_counted >= spacing_goal) begin
                  shelf_pos = move_target;
                  car_mode = CAR_IDLE;
                  done_now = 1'b1;
               end
            end else if (car_mode == CAR_HOMING && !home) begin
               shelf_pos = cfg_home_pos;
               car_mode = CAR_IDLE;
               done_now = 1'b1;
            end
         end
         default: ;
      endcase
      st.motor_run = (car_mode != CAR_IDLE);
      st.busy_res = (car_mode != CAR_IDLE);
      st.done_res = done_now;
      st.position = shelf_pos;
      st.shelves_passed = shelves_counted;
      st.rejected = rej_now;
      return st;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < PRINT_LIMIT) $display("ERROR at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want) begin
         report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                   result_count, name, got, want));
      end
   endtask

   // Result checker: each accepted result against the oldest expectation.
   always @(posedge clock) begin : response_check
      carousel_status_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_status_q.size() == 0) begin
            report_mismatch("result arrived with no request outstanding");
         end else begin
            want = expected_status_q.pop_front();
            check_field("motor_run", rsp_if.motor_run, want.motor_run);
            check_field("busy_res", rsp_if.busy_res, want.busy_res);
            check_field("done_res", rsp_if.done_res, want.done_res);
            check_field("position", rsp_if.position, want.position);
            check_field("shelves_passed", rsp_if.shelves_passed, want.shelves_passed);
            check_field("rejected", rsp_if.rejected, want.rejected);
         end
         result_count++;
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      rsp_if.ready <= (idling_on && $urandom_range(0, 99) < 6) ? 1'b0 : 1'b1;
   end

   // Drive one request; entered and left just after a falling edge.
   task automatic issue_request(req_code_type rt, logic [3:0] tgt, logic shelf, logic home,
                                logic pinned, carousel_status_type pinned_status);
      carousel_status_type predicted;
      while (idling_on && $urandom_range(0, 99) < 6) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= rt;
      req_if.target_shelf <= tgt;
      req_if.shelf_sensor <= shelf;
      req_if.home_sensor <= home;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = predict_carousel(rt, tgt, shelf, home);
      expected_status_q.push_back(pinned ? pinned_status : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_request(req_code_type rt, logic [3:0] tgt, logic shelf, logic home);
      issue_request(rt, tgt, shelf, home, 1'b0, '0);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_settings(logic [15:0] debounce, logic [3:0] home_pos);
      write_register(CSR_DEBOUNCE, debounce);
      cfg_debounce = debounce;
      write_register(CSR_HOME_POS, CSR_DATA_W'(home_pos));
      cfg_home_pos = home_pos;
   endtask

   // Stop requesting and let every outstanding result come back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (expected_status_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // A go command followed by ticks whose shelf level toggles around the lockout time.
   task automatic drive_move_sequence();
      logic [3:0] tgt;
      logic       level;
      int         hold;
      int         hold_max;
      int         guard;
      tgt = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      send_request(REQ_GO, tgt, 1'($urandom), 1'($urandom));
      level = 1'b0;
      guard = 0;
      hold_max = (cfg_debounce < 16'd8) ? int'(cfg_debounce) + 2 : 10;
      while (car_mode == CAR_MOVING && guard < 80) begin
         level = ~level;
         hold = $urandom_range(1, hold_max);
         repeat (hold) begin
            send_request(REQ_TICK, 4'($urandom), level, 1'($urandom));
            guard++;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_request($urandom_range(0, 1) ? REQ_GO : REQ_HOME, 4'($urandom),
                         1'($urandom), 1'($urandom));
         end
      end
   endtask

   // A homing command, a few ticks away from home, then the home switch closes.
   task automatic drive_homing_sequence();
      send_request(REQ_HOME, 4'($urandom), 1'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 4)) send_request(REQ_TICK, 4'($urandom), 1'($urandom), 1'b1);
      send_request(REQ_TICK, 4'($urandom), 1'($urandom), 1'b0);
   endtask

   task automatic run_random_traffic(int budget);
      int start;
      int pick;
      start = requests_sent;
      while (requests_sent - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            drive_move_sequence();
         end else if (pick < 65) begin
            drive_homing_sequence();
         end else if (pick < 85) begin
            send_request(req_code_type'($urandom_range(0, 3)), 4'($urandom),
                         1'($urandom), 1'($urandom));
         end else begin
            send_request($urandom_range(0, 1) ? REQ_GO : REQ_HOME, 4'($urandom),
                         1'($urandom), 1'($urandom));
         end
      end
   endtask

   // Hold a move under the longest lockout with the shelf sensor changing freely.
   task automatic drive_long_lockout();
      while (car_mode == CAR_HOMING) send_request(REQ_TICK, 4'($urandom), 1'($urandom), 1'b0);
      while (car_mode != CAR_MOVING) begin
         send_request(REQ_GO, 4'($urandom_range(1, 15)), 1'($urandom), 1'($urandom));
      end
      repeat (LONG_LOCKOUT_TICKS) begin
         send_request(REQ_TICK, 4'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   initial begin : stimulus
      stim_row_type row;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.req_type = REQ_TICK;
      req_if.target_shelf = 4'd0;
      req_if.shelf_sensor = 1'b1;
      req_if.home_sensor = 1'b1;
      rsp_if.ready = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = directed_rows[i];
         issue_request(row.rt, row.tgt, row.shelf, row.home, row.pinned, row.want);
      end
      drain_results();

      // No lockout, highest home shelf; the move above resumes with counting enabled.
      apply_settings(16'd0, 4'd15);
      run_random_traffic(170);
      drain_results();

      // A stretch with no idling on either side.
      idling_on = 1'b0;
      apply_settings(16'd3, 4'd0);
      run_random_traffic(170);
      drain_results();
      idling_on = 1'b1;

      // Longest lockout: no sensor change is ever accepted.
      apply_settings(16'hFFFF, 4'd9);
      drive_long_lockout();
      drain_results();

      // Back to a short lockout while the move is still pending.
      apply_settings(16'd1, 4'd7);
      run_random_traffic(170);
      drain_results();

      apply_settings(16'($urandom_range(0, 5)), 4'($urandom));
      run_random_traffic(130);
      drain_results();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sci_pkg.sv
rtl/sci_req_if.sv
rtl/sci_rsp_if.sv
rtl/shelf_carousel_indexer.sv
dv/tb_shelf_carousel_indexer.sv
